// ===== rtl/sfrag_pkg.sv =====
// Shared constants and types for the stream fragmenter.
package sfrag_pkg;

  localparam int unsigned PayloadMaxDef = 32;
  localparam int unsigned SeqW          = 14;
  localparam int unsigned ChanW         = 16;
  localparam int unsigned HdrLen        = 4;
  localparam int unsigned HdrCntW       = 2;

  // Header byte positions
  localparam logic [HdrCntW-1:0] HdrChanLo = 2'd0;
  localparam logic [HdrCntW-1:0] HdrChanHi = 2'd1;
  localparam logic [HdrCntW-1:0] HdrSeqLo  = 2'd2;
  localparam logic [HdrCntW-1:0] HdrFlags  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR,
    ST_PAY,
    ST_STORE
  } state_e;

endpackage

// ===== rtl/stream_fragmenter.sv =====
// Stream fragmenter: cuts a byte message into headered datagrams.
// Takes one message byte per cycle while idle; input stalls in every other state.
// A datagram is four header bytes and then its payload bytes, read from the payload RAM.
// A new byte that meets a full buffer is held and stored after that buffer's datagram is out.
// Reset: sequence 0, buffer empty, first flag set, channel 0; RAM not cleared.
module stream_fragmenter
  import sfrag_pkg::*;
#(
  parameter int unsigned PayloadMax = PayloadMaxDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             dest_channel_we_i,
  input  logic [ChanW-1:0] dest_channel_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       data_byte_i,
  input  logic             message_end_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             datagram_end_o
);

  localparam int unsigned FillW = $clog2(PayloadMax + 1);
  localparam int unsigned IdxW  = (PayloadMax > 1) ? $clog2(PayloadMax) : 1;

  state_e             state_q, state_d;
  logic [FillW-1:0]   fill_q, fill_d;
  logic [FillW-1:0]   idx_q, idx_d;
  logic [HdrCntW-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [SeqW-1:0]    seq_q, seq_d;
  logic [ChanW-1:0]   chan_q;
  logic               first_q, first_d;
  logic               last_q, last_d;
  logic               pend_q, pend_d;
  logic [7:0]         pend_byte_q, pend_byte_d;
  logic               pend_end_q, pend_end_d;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         out_byte_q, out_byte_d;
  logic               out_end_q, out_end_d;

  logic [7:0]         mem_q [PayloadMax];
  logic [7:0]         rdata_q;
  logic               rd_en, wr_en;
  logic [FillW-1:0]   rd_addr, wr_addr;
  logic [7:0]         wr_data;

  logic               out_free;
  logic [FillW-1:0]   idx_nxt;
  logic [7:0]         hdr_byte;

  assign out_free = !out_valid_q || !out_stall_i;
  assign idx_nxt  = idx_q + 1'b1;

  always_comb begin
    case (hdr_cnt_q)
      HdrChanLo: hdr_byte = chan_q[7:0];
      HdrChanHi: hdr_byte = chan_q[15:8];
      HdrSeqLo:  hdr_byte = seq_q[7:0];
      HdrFlags:  hdr_byte = {first_q, last_q, seq_q[SeqW-1:8]};
      default:   hdr_byte = 8'h00;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    hdr_cnt_d   = hdr_cnt_q;
    seq_d       = seq_q;
    first_d     = first_q;
    last_d      = last_q;
    pend_d      = pend_q;
    pend_byte_d = pend_byte_q;
    pend_end_d  = pend_end_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    out_end_d   = out_end_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = fill_q;
    wr_data     = data_byte_i;
    in_stall_o  = (state_q != ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (fill_q == FillW'(PayloadMax)) begin
            // full buffer goes out first, hold the new word
            pend_d      = 1'b1;
            pend_byte_d = data_byte_i;
            pend_end_d  = message_end_i;
            last_d      = 1'b0;
            hdr_cnt_d   = '0;
            state_d     = ST_HDR;
          end else begin
            wr_en  = 1'b1;
            fill_d = fill_q + 1'b1;
            if (message_end_i) begin
              pend_d    = 1'b0;
              last_d    = 1'b1;
              hdr_cnt_d = '0;
              state_d   = ST_HDR;
            end
          end
        end
      end
      ST_HDR: begin
        // prefetch first payload word
        rd_en   = 1'b1;
        rd_addr = '0;
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = hdr_byte;
          out_end_d   = (hdr_cnt_q == HdrFlags) && (fill_q == '0);
          hdr_cnt_d   = hdr_cnt_q + 1'b1;
          if (hdr_cnt_q == HdrFlags) begin
            if (fill_q == '0) begin
              seq_d   = seq_q + 1'b1;
              fill_d  = '0;
              first_d = last_q;
              state_d = pend_q ? ST_STORE : ST_IDLE;
            end else begin
              idx_d   = '0;
              state_d = ST_PAY;
            end
          end
        end
      end
      ST_PAY: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = rdata_q;
          out_end_d   = (idx_nxt == fill_q);
          if (idx_nxt < fill_q) begin
            rd_en   = 1'b1;
            rd_addr = idx_nxt;
            idx_d   = idx_nxt;
          end else begin
            seq_d   = seq_q + 1'b1;
            fill_d  = '0;
            first_d = last_q;
            state_d = pend_q ? ST_STORE : ST_IDLE;
          end
        end
      end
      ST_STORE: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = pend_byte_q;
        fill_d  = FillW'(1);
        pend_d  = 1'b0;
        if (pend_end_q) begin
          last_d    = 1'b1;
          hdr_cnt_d = '0;
          state_d   = ST_HDR;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      idx_q       <= '0;
      hdr_cnt_q   <= '0;
      seq_q       <= '0;
      chan_q      <= '0;
      first_q     <= 1'b1;
      last_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      idx_q       <= idx_d;
      hdr_cnt_q   <= hdr_cnt_d;
      seq_q       <= seq_d;
      first_q     <= first_d;
      last_q      <= last_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (dest_channel_we_i) begin
        chan_q <= dest_channel_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_byte_q <= pend_byte_d;
    pend_end_q  <= pend_end_d;
    out_byte_q  <= out_byte_d;
    out_end_q   <= out_end_d;
  end

  // payload RAM, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr[IdxW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr[IdxW-1:0]];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign datagram_end_o = out_end_q;

endmodule

// ===== verif/stream_fragmenter_tb.sv =====
`timescale 1ns / 100ps
// Testbench for the stream fragmenter: random messages checked against a datagram predictor.
module stream_fragmenter_tb
  import sfrag_pkg::*;
();

  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned IdleCycles  = 8;
  localparam int unsigned LongHold    = 400;
  localparam int unsigned PhaseWords  = 30;
  localparam int unsigned NumPhases   = 4;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } dgram_word_t;

  // Predicts the datagram words for each accepted message word and checks the output.
  class frag_scoreboard;
    dgram_word_t      expected_q[$];
    logic [ChanW-1:0] channel;
    logic [SeqW-1:0]  seq_num;
    int unsigned      fill;
    bit               first_frag;
    logic [7:0]       payload [PayloadMaxDef];
    int unsigned      errors;

    function new();
      channel    = '0;
      seq_num    = '0;
      fill       = 0;
      first_frag = 1'b1;
      errors     = 0;
    endfunction

    function void set_channel(logic [ChanW-1:0] value);
      channel = value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void push(logic [7:0] value, logic last);
      dgram_word_t w;
      w.value = value;
      w.last  = last;
      expected_q.push_back(w);
    endfunction

    // Header first, then the buffered payload; advance the sequence once per datagram.
    function void emit_datagram(bit last_frag);
      push(channel[7:0], 1'b0);
      push(channel[15:8], 1'b0);
      push(seq_num[7:0], 1'b0);
      push({first_frag, last_frag, seq_num[13:8]}, fill == 0);
      for (int unsigned i = 0; i < fill; i++) push(payload[i], (i + 1) == fill);
      seq_num    = seq_num + 1'b1;
      fill       = 0;
      first_frag = last_frag;
    endfunction

    function void note_word(logic [7:0] value, logic msg_end);
      // a full buffer goes out as a non-final fragment before the new byte is stored
      if (fill >= PayloadMaxDef) emit_datagram(1'b0);
      payload[fill] = value;
      fill++;
      if (msg_end) emit_datagram(1'b1);
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    task check_word(logic [7:0] value, logic last);
      dgram_word_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected word %02h end=%0b", value, last));
        return;
      end
      want = expected_q.pop_front();
      if (value !== want.value)
        report($sformatf("out_byte %02h, expected %02h", value, want.value));
      if (last !== want.last)
        report($sformatf("datagram_end %0b, expected %0b", last, want.last));
    endtask
  endclass

  logic             clk_i             = 1'b0;
  logic             rst_ni            = 1'b0;
  logic             dest_channel_we_i = 1'b0;
  logic [ChanW-1:0] dest_channel_i    = '0;
  logic             in_valid_i        = 1'b0;
  logic             in_stall_o;
  logic [7:0]       data_byte_i       = '0;
  logic             message_end_i     = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i       = 1'b0;
  logic [7:0]       out_byte_o;
  logic             datagram_end_o;

  frag_scoreboard   sb;
  bit               hold_req    = 1'b0;
  int unsigned      burst_left  = 0;
  int unsigned      words_sent  = 0;
  int unsigned      cycle_count = 0;
  logic [ChanW-1:0] chan_set [NumPhases];

  stream_fragmenter u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .dest_channel_we_i(dest_channel_we_i),
    .dest_channel_i   (dest_channel_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .message_end_i    (message_end_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .datagram_end_o   (datagram_end_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_word(out_byte_o, datagram_end_o);
  end

  // Receiver: stall with a random duty that is re-picked after each random span, or hold off on request.
  initial begin
    int unsigned pct;
    int unsigned span;
    int unsigned hold_left;
    pct       = 0;
    span      = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (span == 0) begin
          span = $urandom_range(80, 10);
          case ($urandom_range(3))
            0:       pct = 0;
            1:       pct = 25;
            2:       pct = 50;
            default: pct = 85;
          endcase
        end
        span--;
        out_stall_i <= ($urandom_range(99) < pct);
      end
    end
  end

  // Offer one word in bursts with random gaps; returns at the negedge after acceptance.
  task automatic send_word(logic [7:0] value, logic msg_end);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= value;
    message_end_i <= msg_end;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(value, msg_end);
    burst_left--;
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_message(int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_word(8'($urandom_range(255)), i == len - 1);
  endtask

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return $urandom_range(6, 1);
    if (r < 70) return $urandom_range(31, 7);
    if (r < 85) return $urandom_range(34, 30);
    return $urandom_range(70, 35);
  endfunction

  // Drop valid and wait for the last datagram to drain before touching the register.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (IdleCycles) @(negedge clk_i);
  endtask

  task automatic write_channel(logic [ChanW-1:0] value);
    dest_channel_we_i <= 1'b1;
    dest_channel_i    <= value;
    @(posedge clk_i);
    sb.set_channel(value);
    @(negedge clk_i);
    dest_channel_we_i <= 1'b0;
  endtask

  initial begin
    sb = new();
    chan_set[0] = 16'hffff;
    chan_set[1] = 16'h0000;
    chan_set[2] = 16'($urandom_range(16'hffff));
    chan_set[3] = 16'h8001;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_channel(16'($urandom_range(16'hffff)));

    // single-word messages at the byte extremes, a two-word one, then a three-word message
    send_word(8'h00, 1'b1);
    send_word(8'hff, 1'b1);
    send_word(8'hff, 1'b0);
    send_word(8'h00, 1'b1);
    send_message(3);

    for (int unsigned p = 0; p < NumPhases; p++) begin
      wait_idle();
      write_channel(chan_set[p]);
      words_sent = 0;
      if (p == 0) begin
        // exactly one full buffer, then a full buffer followed by the final byte
        send_message(PayloadMaxDef);
        send_message(PayloadMaxDef + 1);
      end
      if (p == 2) begin
        // block the output while a long message keeps arriving
        hold_req = 1'b1;
        send_message(70);
      end
      while (words_sent < PhaseWords) send_message(pick_len());
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
